// ----- hdl/rrwl_pkg.sv -----
// Shared types and codes for the reentrant read/write lock manager.
package rrwl_pkg;

    localparam logic [2:0] FUNC_ACQ_READ  = 3'd0;
    localparam logic [2:0] FUNC_ACQ_WRITE = 3'd1;
    localparam logic [2:0] FUNC_TRY_READ  = 3'd2;
    localparam logic [2:0] FUNC_TRY_WRITE = 3'd3;
    localparam logic [2:0] FUNC_REL_READ  = 3'd4;
    localparam logic [2:0] FUNC_REL_WRITE = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REFUSED  = 2'd1;
    localparam logic [1:0] ST_NOT_HELD = 2'd2;
    localparam logic [1:0] ST_LIMIT    = 2'd3;

    localparam int ID_BITS  = 4;
    localparam int OUT_BITS = 16;

    typedef struct packed {
        logic [2:0]         func;
        logic [ID_BITS-1:0] requester;
        logic               others_waiting;
    } request_t;

    typedef struct packed {
        logic                granted;
        logic [1:0]          status;
        logic                lock_free;
        logic [OUT_BITS-1:0] read_total;
        logic [OUT_BITS-1:0] write_holds;
        logic [ID_BITS-1:0]  owner_id;
        logic                owner_valid;
        logic [OUT_BITS-1:0] requester_read_holds;
    } result_t;

endpackage

// ----- hdl/rrwl_engine.sv -----
// Lock state registers, per-requester read hold table and the request decision logic.
module rrwl_engine #(
    parameter int REQUESTERS = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              enable,
    input  logic              fair_mode,
    input  rrwl_pkg::request_t req,
    output rrwl_pkg::result_t  result
);
    import rrwl_pkg::*;

    localparam int TABLE_DEPTH = (REQUESTERS < 16) ? REQUESTERS : 16;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);

    logic [COUNT_BITS-1:0] write_count_reg, write_count_next;
    logic [COUNT_BITS-1:0] read_count_reg, read_count_next;
    logic [ID_BITS-1:0]    writer_id_reg, writer_id_next;
    logic                  writer_held_reg, writer_held_next;
    logic [COUNT_BITS-1:0] holds_reg [TABLE_DEPTH];

    logic                  in_range;
    logic [IDX_BITS-1:0]   idx;
    logic [COUNT_BITS-1:0] my_holds, my_holds_next;
    logic                  is_owner;
    logic                  block;
    logic                  do_read;
    logic                  do_write;
    logic [1:0]            status;
    logic                  freed;

    assign in_range = (REQUESTERS >= 16) || (32'(req.requester) < 32'(REQUESTERS));
    assign idx      = req.requester[IDX_BITS-1:0];
    assign my_holds = in_range ? holds_reg[idx] : '0;
    assign is_owner = writer_held_reg && (writer_id_reg == req.requester);
    assign block    = fair_mode && req.others_waiting;

    always_comb
    begin
        write_count_next = write_count_reg;
        read_count_next  = read_count_reg;
        writer_id_next   = writer_id_reg;
        writer_held_next = writer_held_reg;
        my_holds_next    = my_holds;
        status           = ST_REFUSED;
        freed            = 1'b0;
        do_read          = 1'b0;
        do_write         = 1'b0;

        if (in_range)
        begin
            unique case (req.func) inside
                FUNC_ACQ_READ, FUNC_TRY_READ:
                begin
                    if (writer_held_reg && !is_owner)
                        status = ST_REFUSED;
                    else if (!writer_held_reg && block && (req.func == FUNC_ACQ_READ)
                             && (my_holds == '0))
                        status = ST_REFUSED;
                    else if (&read_count_reg)
                        status = ST_LIMIT;
                    else
                        do_read = 1'b1;
                end
                FUNC_ACQ_WRITE, FUNC_TRY_WRITE:
                begin
                    if ((read_count_reg != '0) || (write_count_reg != '0))
                    begin
                        if (!is_owner)
                            status = ST_REFUSED;
                        else if (&write_count_reg)
                            status = ST_LIMIT;
                        else
                            do_write = 1'b1;
                    end
                    else if (block && (req.func == FUNC_ACQ_WRITE))
                        status = ST_REFUSED;
                    else
                    begin
                        status           = ST_OK;
                        write_count_next = COUNT_BITS'(1);
                        writer_id_next   = req.requester;
                        writer_held_next = 1'b1;
                    end
                end
                FUNC_REL_READ:
                begin
                    if ((my_holds == '0) || (read_count_reg == '0))
                        status = ST_NOT_HELD;
                    else
                    begin
                        status          = ST_OK;
                        my_holds_next   = my_holds - COUNT_BITS'(1);
                        read_count_next = read_count_reg - COUNT_BITS'(1);
                        freed           = (read_count_next == '0) && (write_count_reg == '0);
                    end
                end
                FUNC_REL_WRITE:
                begin
                    if (!is_owner || (write_count_reg == '0))
                        status = ST_NOT_HELD;
                    else
                    begin
                        status           = ST_OK;
                        write_count_next = write_count_reg - COUNT_BITS'(1);
                        if (write_count_next == '0)
                        begin
                            writer_held_next = 1'b0;
                            writer_id_next   = '0;
                            freed            = 1'b1;
                        end
                    end
                end
                default:
                    status = ST_REFUSED;
            endcase

            if (do_read)
            begin
                status          = ST_OK;
                read_count_next = read_count_reg + COUNT_BITS'(1);
                my_holds_next   = my_holds + COUNT_BITS'(1);
            end
            if (do_write)
            begin
                status           = ST_OK;
                write_count_next = write_count_reg + COUNT_BITS'(1);
            end
        end
    end

    always_comb
    begin
        result.granted              = (status == ST_OK);
        result.status               = status;
        result.lock_free            = freed;
        result.read_total           = OUT_BITS'(read_count_next);
        result.write_holds          = OUT_BITS'(write_count_next);
        result.owner_id             = writer_held_next ? writer_id_next : '0;
        result.owner_valid          = writer_held_next;
        result.requester_read_holds = in_range ? OUT_BITS'(my_holds_next) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_count_reg <= '0;
            read_count_reg  <= '0;
            writer_id_reg   <= '0;
            writer_held_reg <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++)
                holds_reg[i] <= '0;
        end
        else if (enable)
        begin
            write_count_reg <= write_count_next;
            read_count_reg  <= read_count_next;
            writer_id_reg   <= writer_id_next;
            writer_held_reg <= writer_held_next;
            if (in_range)
                holds_reg[idx] <= my_holds_next;
        end
    end

endmodule

// ----- hdl/reentrant_read_write_lock_manager.sv -----
// Reentrant read/write lock manager: request register, lock engine and result register.
// A request passes the request register and engine into the result register, done high
// for one cycle. Throughput: one request per cycle, busy is never raised; the single
// read-modify-write of counts and one table entry sets this. The receiver cannot stall.
// Reset (rst_n low, asynchronous): counts, owner, read hold table and fair_mode clear.
module reentrant_read_write_lock_manager #(
    parameter int REQUESTERS = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    func,
    input  logic [rrwl_pkg::ID_BITS-1:0]  requester,
    input  logic                          others_waiting,
    input  logic                          cfg_write,
    input  logic                          cfg_data,
    output logic                          done,
    output logic                          granted,
    output logic [1:0]                    status,
    output logic                          lock_free,
    output logic [rrwl_pkg::OUT_BITS-1:0] read_total,
    output logic [rrwl_pkg::OUT_BITS-1:0] write_holds,
    output logic [rrwl_pkg::ID_BITS-1:0]  owner_id,
    output logic                          owner_valid,
    output logic [rrwl_pkg::OUT_BITS-1:0] requester_read_holds
);
    import rrwl_pkg::*;

    logic     fair_mode_reg;
    logic     req_valid_reg;
    request_t req_reg;
    logic     done_reg;
    result_t  result_reg;
    result_t  result_next;

    assign busy = 1'b0;

    rrwl_engine #(
        .REQUESTERS (REQUESTERS),
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (req_valid_reg),
        .fair_mode (fair_mode_reg),
        .req       (req_reg),
        .result    (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fair_mode_reg <= 1'b0;
            req_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                fair_mode_reg <= cfg_data;
            req_valid_reg <= start && !busy;
            done_reg      <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg.func           <= func;
            req_reg.requester      <= requester;
            req_reg.others_waiting <= others_waiting;
        end
        if (req_valid_reg)
            result_reg <= result_next;
    end

    assign done                 = done_reg;
    assign granted              = result_reg.granted;
    assign status               = result_reg.status;
    assign lock_free            = result_reg.lock_free;
    assign read_total           = result_reg.read_total;
    assign write_holds          = result_reg.write_holds;
    assign owner_id             = result_reg.owner_id;
    assign owner_valid          = result_reg.owner_valid;
    assign requester_read_holds = result_reg.requester_read_holds;

endmodule
